>>> hdl/hbsa_pkg.sv
// hbsa_pkg: shared types and constants of the hierarchical bitmap slot allocator
// no dependencies; imported by hbsa_fz, hbsa_mem and the top level
package hbsa_pkg;

  localparam int unsigned FANOUT            = 64;
  localparam int unsigned ENTRIES_PER_BLOCK = 31;
  localparam int unsigned GRP_W             = 6;   // group number bits
  localparam int unsigned BIDX_W            = 6;   // block bits within a group
  localparam int unsigned BLK_FULL_W        = 12;  // widest block number
  localparam int unsigned IDX_W             = 5;   // entry bits within a block
  localparam int unsigned ID_W              = 17;
  localparam int unsigned CNT_W             = 17;
  localparam int unsigned STATUS_W          = 2;
  localparam int unsigned FZ_W              = 32;  // first-zero unit width
  localparam int unsigned OCC_W             = 31;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL     = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_BAD_FREE = 2'd2;

  // id / 31 == (id * DIV31_MUL) >> DIV31_SHIFT, exact for all 17-bit ids
  localparam logic [17:0]  DIV31_MUL   = 18'd135301;
  localparam int unsigned  DIV31_SHIFT = 22;
  localparam int unsigned  PROD_W      = 34;

  typedef struct packed {
    logic                  occ_rd;
    logic                  occ_we;
    logic                  sum_rd;
    logic                  sum_we;
    logic [BLK_FULL_W-1:0] blk;
    logic [GRP_W-1:0]      grp;
    logic [OCC_W-1:0]      occ_wdata;
    logic [FANOUT-1:0]     sum_wdata;
  } mem_req_t;

endpackage

>>> hdl/hbsa_fz.sv
// hbsa_fz: shared first-zero finder over one 32-bit word
// depends on hbsa_pkg
module hbsa_fz import hbsa_pkg::*; (
  input  logic [FZ_W-1:0]  word_i,
  output logic             found_o,
  output logic [IDX_W-1:0] index_o
);

  logic [FZ_W-1:0] zeros;
  logic [FZ_W-1:0] lowest;

  assign zeros   = ~word_i;
  // isolate the lowest set bit of the inverted word
  assign lowest  = zeros & (~zeros + FZ_W'(1));
  assign found_o = |zeros;

  always_comb begin
    index_o = '0;
    for (int i = 0; i < FZ_W; i++) begin
      if (lowest[i]) begin
        index_o = index_o | IDX_W'(i);
      end
    end
  end

endmodule

>>> hdl/hbsa_mem.sv
// hbsa_mem: block occupancy memory and per-group full summary memory,
// with the clearing pass after reset; depends on hbsa_pkg
module hbsa_mem import hbsa_pkg::*; #(
  parameter int unsigned NUM_BLOCKS = 4096
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  mem_req_t          req_i,
  output logic              busy_o,
  output logic [OCC_W-1:0]  occ_rdata_o,
  output logic [FANOUT-1:0] sum_rdata_o
);

  localparam int unsigned BLK_W = $clog2(NUM_BLOCKS);

  logic [OCC_W-1:0]  occ_mem [NUM_BLOCKS];
  logic [FANOUT-1:0] sum_mem [FANOUT];

  logic [BLK_W-1:0]  clr_cnt_q;
  logic              busy_q;
  logic              clr_sum;
  logic [OCC_W-1:0]  occ_rdata_q;
  logic [FANOUT-1:0] sum_rdata_q;

  // blocks past the end of the block space are held full
  function automatic logic [FANOUT-1:0] sum_reset(input logic [GRP_W-1:0] g);
    logic [FANOUT-1:0] v;
    logic [BLK_FULL_W-1:0] blk;
    v = '0;
    for (int b = 0; b < FANOUT; b++) begin
      blk = {g, BIDX_W'(b)};
      v[b] = ({1'b0, blk} >= (BLK_FULL_W+1)'(NUM_BLOCKS));
    end
    return v;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q    <= 1'b1;
      clr_cnt_q <= '0;
    end else if (busy_q) begin
      if (clr_cnt_q == BLK_W'(NUM_BLOCKS - 1)) begin
        busy_q <= 1'b0;
      end else begin
        clr_cnt_q <= clr_cnt_q + BLK_W'(1);
      end
    end
  end

  assign clr_sum = busy_q && ({1'b0, clr_cnt_q} < (BLK_W+1)'(FANOUT));

  always_ff @(posedge clk_i) begin
    if (busy_q) begin
      // entry zero stays reserved after reset
      occ_mem[clr_cnt_q] <= (clr_cnt_q == '0) ? OCC_W'(1) : '0;
      if (clr_sum) begin
        sum_mem[clr_cnt_q[GRP_W-1:0]] <= sum_reset(clr_cnt_q[GRP_W-1:0]);
      end
    end else begin
      if (req_i.occ_we) begin
        occ_mem[req_i.blk[BLK_W-1:0]] <= req_i.occ_wdata;
      end
      if (req_i.sum_we) begin
        sum_mem[req_i.grp] <= req_i.sum_wdata;
      end
    end
    if (req_i.occ_rd) begin
      occ_rdata_q <= occ_mem[req_i.blk[BLK_W-1:0]];
    end
    if (req_i.sum_rd) begin
      sum_rdata_q <= sum_mem[req_i.grp];
    end
  end

  assign busy_o      = busy_q;
  assign occ_rdata_o = occ_rdata_q;
  assign sum_rdata_o = sum_rdata_q;

endmodule

>>> hdl/hierarchical_bitmap_slot_allocator_core.sv
// hierarchical_bitmap_slot_allocator_core: top level with the command sequencer,
// top summary register and output register; uses hbsa_pkg, hbsa_fz and hbsa_mem
//
//  channel  | dir | tdata (low bit up)                          | tuser
//  s_axis   | in  | slot_id[16:0], zero fill to 24 bits         | command
//  m_axis   | out | status[1:0], allocated_id[18:2],            | -
//           |     | used_count[35:19], zero fill to 40 bits     |
//
// allocate: group search (ST_G_LO, ST_G_HI), summary read (ST_S_RD), block search
// (ST_B_LO, ST_B_HI), occupancy read (ST_O_RD), entry update (ST_IDX), ST_OUT; each
// half-word search of a 64-bit summary is one pass of the shared 32-bit first-zero
// unit; a level that comes up empty goes to ST_OUT. free: ST_DIV, ST_F_RD, ST_F_CHK and
// ST_OUT (out of range: ST_OUT alone); a new beat is taken only back in idle. after
// reset the clearing pass covers every block with s_axis_tready_o low. a result waits
// in the output register; the sequencer stalls in its last step until that is free.
module hierarchical_bitmap_slot_allocator_core import hbsa_pkg::*; #(
  parameter int unsigned NUM_BLOCKS = 4096
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [23:0] s_axis_tdata_i,   // slot_id
  input  logic        s_axis_tuser_i,   // command
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [39:0] m_axis_tdata_o    // status, allocated_id, used_count
);

  localparam int unsigned NUM_GROUPS  = (NUM_BLOCKS + FANOUT - 1) / FANOUT;
  localparam int unsigned MAX_ENTRIES = NUM_BLOCKS * ENTRIES_PER_BLOCK;

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_G_LO  = 4'd1;
  localparam logic [3:0] ST_G_HI  = 4'd2;
  localparam logic [3:0] ST_S_RD  = 4'd3;
  localparam logic [3:0] ST_B_LO  = 4'd4;
  localparam logic [3:0] ST_B_HI  = 4'd5;
  localparam logic [3:0] ST_O_RD  = 4'd6;
  localparam logic [3:0] ST_IDX   = 4'd7;
  localparam logic [3:0] ST_DIV   = 4'd8;
  localparam logic [3:0] ST_F_RD  = 4'd9;
  localparam logic [3:0] ST_F_CHK = 4'd10;
  localparam logic [3:0] ST_OUT   = 4'd11;

  function automatic logic [FANOUT-1:0] top_reset();
    logic [FANOUT-1:0] v;
    v = '0;
    for (int g = 0; g < FANOUT; g++) begin
      v[g] = (g >= int'(NUM_GROUPS));
    end
    return v;
  endfunction

  localparam logic [FANOUT-1:0] TOP_RST = top_reset();

  logic [3:0]            st_q, st_d;
  logic [ID_W-1:0]       id_q, id_d;
  logic [GRP_W-1:0]      g_q, g_d;
  logic [BLK_FULL_W-1:0] blk_q, blk_d;
  logic [IDX_W-1:0]      idx_q, idx_d;
  logic [PROD_W-1:0]     prod_q, prod_d;
  logic [FANOUT-1:0]     top_q, top_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic [STATUS_W-1:0]   status_q, status_d;
  logic [ID_W-1:0]       grant_q, grant_d;

  logic                  out_valid_q, out_valid_d;
  logic [STATUS_W-1:0]   out_status_q, out_status_d;
  logic [ID_W-1:0]       out_grant_q, out_grant_d;
  logic [CNT_W-1:0]      out_cnt_q, out_cnt_d;

  logic                  in_beat;
  logic                  mem_busy;
  mem_req_t              mem_req;
  logic [OCC_W-1:0]      occ_rdata;
  logic [FANOUT-1:0]     sum_rdata;

  logic [FZ_W-1:0]       fz_word;
  logic                  fz_found;
  logic [IDX_W-1:0]      fz_index;

  logic [GRP_W-1:0]      g_new;
  logic [BLK_FULL_W-1:0] blk_new;
  logic [OCC_W-1:0]      occ_new;
  logic [FANOUT-1:0]     sum_new;

  hbsa_fz u_fz (
    .word_i  (fz_word),
    .found_o (fz_found),
    .index_o (fz_index)
  );

  hbsa_mem #(
    .NUM_BLOCKS (NUM_BLOCKS)
  ) u_mem (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (mem_req),
    .busy_o      (mem_busy),
    .occ_rdata_o (occ_rdata),
    .sum_rdata_o (sum_rdata)
  );

  assign s_axis_tready_o = (st_q == ST_IDLE) && !mem_busy;
  assign in_beat         = s_axis_tvalid_i && s_axis_tready_o;

  // operand of the shared first-zero unit
  always_comb begin
    case (st_q)
      ST_G_LO: fz_word = top_q[FZ_W-1:0];
      ST_G_HI: fz_word = top_q[FANOUT-1:FZ_W];
      ST_B_LO: fz_word = sum_rdata[FZ_W-1:0];
      ST_B_HI: fz_word = sum_rdata[FANOUT-1:FZ_W];
      ST_IDX:  fz_word = {1'b1, occ_rdata};
      default: fz_word = '1;
    endcase
  end

  always_comb begin
    st_d         = st_q;
    id_d         = id_q;
    g_d          = g_q;
    blk_d        = blk_q;
    idx_d        = idx_q;
    prod_d       = prod_q;
    top_d        = top_q;
    cnt_d        = cnt_q;
    status_d     = status_q;
    grant_d      = grant_q;
    out_valid_d  = out_valid_q && !m_axis_tready_i;
    out_status_d = out_status_q;
    out_grant_d  = out_grant_q;
    out_cnt_d    = out_cnt_q;
    mem_req      = '0;
    g_new        = '0;
    blk_new      = '0;
    occ_new      = '0;
    sum_new      = '0;

    case (st_q)
      ST_IDLE: begin
        if (in_beat) begin
          id_d     = s_axis_tdata_i[ID_W-1:0];
          status_d = STATUS_OK;
          grant_d  = '0;
          if (s_axis_tuser_i == CMD_ALLOC) begin
            st_d = ST_G_LO;
          end else if (s_axis_tdata_i[ID_W-1:0] >= ID_W'(MAX_ENTRIES)) begin
            status_d = STATUS_BAD_FREE;
            st_d     = ST_OUT;
          end else begin
            st_d = ST_DIV;
          end
        end
      end
      ST_G_LO, ST_G_HI: begin
        g_new = {(st_q == ST_G_HI), fz_index};
        g_d   = g_new;
        if (fz_found && ({1'b0, g_new} < (GRP_W+1)'(NUM_GROUPS))) begin
          st_d = ST_S_RD;
        end else if (!fz_found && (st_q == ST_G_LO)) begin
          st_d = ST_G_HI;
        end else begin
          status_d = STATUS_FULL;
          st_d     = ST_OUT;
        end
      end
      ST_S_RD: begin
        mem_req.sum_rd = 1'b1;
        mem_req.grp    = g_q;
        st_d           = ST_B_LO;
      end
      ST_B_LO, ST_B_HI: begin
        blk_new = {g_q, (st_q == ST_B_HI), fz_index};
        blk_d   = blk_new;
        if (fz_found && ({1'b0, blk_new} < (BLK_FULL_W+1)'(NUM_BLOCKS))) begin
          st_d = ST_O_RD;
        end else if (!fz_found && (st_q == ST_B_LO)) begin
          st_d = ST_B_HI;
        end else begin
          status_d = STATUS_FULL;
          st_d     = ST_OUT;
        end
      end
      ST_O_RD: begin
        mem_req.occ_rd = 1'b1;
        mem_req.blk    = blk_q;
        st_d           = ST_IDX;
      end
      ST_IDX: begin
        occ_new = occ_rdata | (OCC_W'(1) << fz_index);
        sum_new = sum_rdata | (FANOUT'(1) << blk_q[BIDX_W-1:0]);
        st_d    = ST_OUT;
        if (fz_found) begin
          mem_req.occ_we    = 1'b1;
          mem_req.blk       = blk_q;
          mem_req.occ_wdata = occ_new;
          // block just became full: mark it, and the group if that fills too
          if (&occ_new) begin
            mem_req.sum_we    = 1'b1;
            mem_req.grp       = g_q;
            mem_req.sum_wdata = sum_new;
            if (&sum_new) begin
              top_d[g_q] = 1'b1;
            end
          end
          cnt_d   = cnt_q + CNT_W'(1);
          grant_d = ID_W'({blk_q, 5'b0}) - ID_W'(blk_q) + ID_W'(fz_index);
        end else begin
          status_d = STATUS_FULL;
        end
      end
      ST_DIV: begin
        prod_d = {17'd0, id_q} * {16'd0, DIV31_MUL};
        st_d   = ST_F_RD;
      end
      ST_F_RD: begin
        blk_new        = prod_q[DIV31_SHIFT+BLK_FULL_W-1:DIV31_SHIFT];
        blk_d          = blk_new;
        idx_d          = IDX_W'(id_q - (ID_W'({blk_new, 5'b0}) - ID_W'(blk_new)));
        mem_req.occ_rd = 1'b1;
        mem_req.sum_rd = 1'b1;
        mem_req.blk    = blk_new;
        mem_req.grp    = blk_new[BLK_FULL_W-1:BIDX_W];
        st_d           = ST_F_CHK;
      end
      ST_F_CHK: begin
        st_d = ST_OUT;
        if (!occ_rdata[idx_q]) begin
          status_d = STATUS_BAD_FREE;
        end else begin
          mem_req.occ_we    = 1'b1;
          mem_req.blk       = blk_q;
          mem_req.occ_wdata = occ_rdata & ~(OCC_W'(1) << idx_q);
          mem_req.sum_we    = 1'b1;
          mem_req.grp       = blk_q[BLK_FULL_W-1:BIDX_W];
          mem_req.sum_wdata = sum_rdata & ~(FANOUT'(1) << blk_q[BIDX_W-1:0]);
          top_d[blk_q[BLK_FULL_W-1:BIDX_W]] = 1'b0;
          cnt_d = cnt_q - CNT_W'(1);
        end
      end
      ST_OUT: begin
        if (!out_valid_q || m_axis_tready_i) begin
          out_valid_d  = 1'b1;
          out_status_d = status_q;
          out_grant_d  = grant_q;
          out_cnt_d    = cnt_q;
          st_d         = ST_IDLE;
        end
      end
      default: begin
        st_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_IDLE;
      top_q       <= TOP_RST;
      cnt_q       <= CNT_W'(1);
      out_valid_q <= 1'b0;
    end else begin
      st_q        <= st_d;
      top_q       <= top_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    id_q         <= id_d;
    g_q          <= g_d;
    blk_q        <= blk_d;
    idx_q        <= idx_d;
    prod_q       <= prod_d;
    status_q     <= status_d;
    grant_q      <= grant_d;
    out_status_q <= out_status_d;
    out_grant_q  <= out_grant_d;
    out_cnt_q    <= out_cnt_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {4'b0, out_cnt_q, out_grant_q, out_status_q};

`ifndef ASSERT_OFF
  a_no_beat_while_clearing: assert property (
    @(posedge clk_i) disable iff (!rst_ni) mem_busy |-> !s_axis_tready_o)
    else $error("input ready during clearing pass");

  a_count_in_range: assert property (
    @(posedge clk_i) disable iff (!rst_ni) cnt_q <= CNT_W'(MAX_ENTRIES))
    else $error("entry count beyond capacity");

  a_fail_has_no_grant: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_status_q != STATUS_OK)) |-> (out_grant_q == '0))
    else $error("failed command carries a granted id");

  a_no_write_when_idle: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_IDLE || st_q == ST_OUT) |-> !(mem_req.occ_we || mem_req.sum_we))
    else $error("bitmap write outside command update");

  a_count_step: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_IDLE) |=> (cnt_q == $past(cnt_q)))
    else $error("entry count moved without a command");
`endif

endmodule
